FILE: hdl/barb_pkg.sv
// shared types and constants of the bus arbiter
// no dependencies
package barb_pkg;

	localparam int MAX_MASTERS = 8;
	localparam int QDEPTH      = 8;
	localparam int QIDX_W      = $clog2(QDEPTH);
	localparam int CNT_W       = $clog2(QDEPTH + 1);
	localparam int ID_W        = 3;
	localparam int MC_W        = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_COUNT = 1'b1;

	localparam logic [MC_W-1:0] MC_RESET = 4'd4;

	typedef enum logic [1:0] {
		EV_REQ  = 2'd0,
		EV_TICK = 2'd1,
		EV_REL  = 2'd2,
		EV_NONE = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic [1:0]      req_type;
		logic [ID_W-1:0] mst_id;
	} req_t;

	typedef struct packed {
		logic             granted;
		logic [ID_W-1:0]  owner;
		logic             bus_busy;
		logic             dropped;
		logic [CNT_W-1:0] pending;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

FILE: hdl/barb_if.sv
// valid/ready channel interfaces for event and result words
// depends on barb_pkg
interface barb_req_if import barb_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface barb_rsp_if import barb_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/barb_ctrl.sv
// controller: accepts one event word, runs it, hands the result to the output register
// depends on barb_pkg
module barb_ctrl import barb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.exec) state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/barb_dp.sv
// datapath: id queue, round-robin pointer, bus owner, config and result register
// depends on barb_pkg
module barb_dp import barb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  req_t                  req_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output rsp_t                  rsp_data
);

	req_t             ev_s1;
	logic [ID_W-1:0]  q_q [QDEPTH];
	logic [ID_W-1:0]  q_n [QDEPTH];
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [ID_W-1:0]  ptr_q, ptr_n;
	logic             busy_q, busy_n;
	logic [ID_W-1:0]  owner_q, owner_n;
	logic             policy_q;
	logic [MC_W-1:0]  mc_q;
	rsp_t             rsp_q;

	logic [ID_W-1:0]   last_m;
	logic [ID_W-1:0]   ptr_adv;
	logic [QDEPTH-1:0] match;
	logic              hit;
	logic [QIDX_W-1:0] hit_pos;
	logic              shift;
	logic [QIDX_W-1:0] sh_pos;
	logic              grant_n;
	logic              drop_n;

	// last master index in the rotation
	always_comb begin
		if (mc_q == '0) begin
			last_m = '0;
		end else if (mc_q > MC_W'(MAX_MASTERS)) begin
			last_m = ID_W'(MAX_MASTERS - 1);
		end else begin
			last_m = ID_W'(mc_q - 1'b1);
		end
		ptr_adv = (ptr_q >= last_m) ? '0 : ptr_q + 1'b1;
	end

	// search the queue for the first entry of the next master
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < QDEPTH; i++) begin
			match[i] = (CNT_W'(i) < cnt_q) && (q_q[i] == ptr_adv);
		end
		for (int i = QDEPTH - 1; i >= 0; i--) begin
			if (match[i]) hit_pos = QIDX_W'(i);
		end
		hit = |match;
	end

	always_comb begin
		q_n     = q_q;
		cnt_n   = cnt_q;
		ptr_n   = ptr_q;
		busy_n  = busy_q;
		owner_n = owner_q;
		grant_n = 1'b0;
		drop_n  = 1'b0;
		shift   = 1'b0;
		sh_pos  = '0;
		unique case (ev_kind_t'(ev_s1.req_type))
			EV_REQ: begin
				if (cnt_q < CNT_W'(QDEPTH)) begin
					q_n[cnt_q[QIDX_W-1:0]] = ev_s1.mst_id;
					cnt_n = cnt_q + 1'b1;
				end else begin
					drop_n = 1'b1;
				end
			end
			EV_TICK: begin
				if (!busy_q) begin
					if (policy_q) begin
						ptr_n = ptr_adv;
						if (hit) begin
							shift   = 1'b1;
							sh_pos  = hit_pos;
							owner_n = ptr_adv;
						end
					end else if (cnt_q != '0) begin
						shift   = 1'b1;
						owner_n = q_q[0];
					end
				end
			end
			EV_REL: begin
				busy_n = 1'b0;
			end
			EV_NONE: begin
			end
		endcase
		// remove the granted entry, later entries move up by one
		if (shift) begin
			for (int i = 0; i < QDEPTH - 1; i++) begin
				if (QIDX_W'(i) >= sh_pos) q_n[i] = q_q[i + 1];
			end
			cnt_n   = cnt_q - 1'b1;
			busy_n  = 1'b1;
			grant_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ptr_q    <= '0;
			busy_q   <= 1'b0;
			owner_q  <= '0;
			policy_q <= 1'b0;
			mc_q     <= MC_RESET;
		end else begin
			if (cmd.exec) begin
				cnt_q   <= cnt_n;
				ptr_q   <= ptr_n;
				busy_q  <= busy_n;
				owner_q <= owner_n;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_POLICY:       policy_q <= cfg_data[0];
					CFG_MASTER_COUNT: mc_q     <= cfg_data[MC_W-1:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) ev_s1 <= req_data;
		if (cmd.exec) begin
			q_q              <= q_n;
			rsp_q.granted    <= grant_n;
			rsp_q.owner      <= owner_n;
			rsp_q.bus_busy   <= busy_n;
			rsp_q.dropped    <= drop_n;
			rsp_q.pending    <= cnt_n;
		end
	end

	assign rsp_data = rsp_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QDEPTH))
		else $error("queue count above depth");

	a_grant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && grant_n |=> busy_q && (cnt_q == $past(cnt_q) - 1'b1))
		else $error("grant did not take the bus or pop the queue");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && drop_n |-> cnt_q == CNT_W'(QDEPTH))
		else $error("request dropped while queue had room");

	a_grant_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && grant_n |-> !busy_q)
		else $error("grant while bus busy");

endmodule

FILE: hdl/bus_arbiter_fifo_round_robin_core.sv
// Shared-bus arbiter with FIFO or round-robin grant order.
// Channels: req (sink) carries one event word: req_type (0 request, 1 tick,
// 2 release) and mst_id. rsp (source) returns one result word per event:
// granted, owner, bus_busy, dropped and pending (queue fill after the event).
// Configuration: cfg_we with cfg_idx 0 writes policy (0 FIFO, 1 round robin),
// cfg_idx 1 writes master_count; write only while no event is in flight.
// An accepted event is captured in the event register and runs once the
// output register is free; its result is then registered there.
// The controller takes no new event until the current one has run: it
// captures the event, then does the queue search and compaction.
// The next event is accepted while a result waits in the output register;
// if the receiver stalls, one more event is captured and then req.ready
// stays low until the output register is taken.
// Reset: queue count, round-robin pointer, busy flag and owner clear,
// policy goes to FIFO and master_count to 4; queue entries are left as is.
// Depends on barb_pkg, barb_if, barb_ctrl and barb_dp.
module bus_arbiter_fifo_round_robin_core import barb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	barb_req_if.sink              req,
	barb_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;

	barb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	barb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req.data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rsp_data (rsp.data)
	);

endmodule

FILE: test/bus_arbiter_fifo_round_robin_core_tb.sv
// self-checking testbench for the shared-bus arbiter: directed events, then random traffic
// under several policy and master count settings, checked against an in-bench arbiter model
// depends on barb_pkg, barb_if and bus_arbiter_fifo_round_robin_core
module bus_arbiter_fifo_round_robin_core_tb import barb_pkg::*; ();

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	barb_req_if req_ch ();
	barb_rsp_if rsp_ch ();

	bus_arbiter_fifo_round_robin_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// arbiter model state
	logic [ID_W-1:0] mq_ids [QDEPTH];
	int              mq_cnt;
	logic [ID_W-1:0] rr_ptr;
	logic            bus_held;
	logic [ID_W-1:0] cur_owner;
	logic            pol_rr;
	logic [MC_W-1:0] mc_reg;

	req_t event_q [$];
	rsp_t grant_q [$];
	rsp_t want;
	int   err_cnt = 0;
	int   word_num = 0;
	int   src_idle;
	int   snk_idle;

	int ph_pol [12] = '{1, 1, 0, 1, 1, 1, 0, 1, 0, 1, 1, 0};
	int ph_mc  [12] = '{8, 3, 0, 0, 15, 1, 8, 9, 4, 5, 2, 12};

	function automatic int eff_masters();
		int n;
		n = mc_reg;
		if (n == 0)
			n = 1;
		if (n > MAX_MASTERS)
			n = MAX_MASTERS;
		return n;
	endfunction

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < mq_cnt; i++)
			mq_ids[i] = mq_ids[i + 1];
		mq_cnt--;
	endfunction

	function automatic rsp_t arb_predict(req_t ev);
		rsp_t r;
		int   n;
		int   hit;
		logic gnt;
		logic drp;
		gnt = 1'b0;
		drp = 1'b0;
		case (ev.req_type)
			EV_REQ: begin
				if (mq_cnt < QDEPTH) begin
					mq_ids[mq_cnt] = ev.mst_id;
					mq_cnt++;
				end else begin
					drp = 1'b1;
				end
			end
			EV_TICK: begin
				if (!bus_held) begin
					if (pol_rr) begin
						n = eff_masters();
						if (int'(rr_ptr) >= n - 1)
							rr_ptr = '0;
						else
							rr_ptr = rr_ptr + 1'b1;
						hit = -1;
						for (int i = 0; i < mq_cnt; i++)
							if (hit < 0 && mq_ids[i] == rr_ptr)
								hit = i;
						if (hit >= 0) begin
							drop_entry(hit);
							cur_owner = rr_ptr;
							bus_held = 1'b1;
							gnt = 1'b1;
						end
					end else if (mq_cnt > 0) begin
						cur_owner = mq_ids[0];
						drop_entry(0);
						bus_held = 1'b1;
						gnt = 1'b1;
					end
				end
			end
			EV_REL: bus_held = 1'b0;
			default: ;
		endcase
		r.granted  = gnt;
		r.owner    = cur_owner;
		r.bus_busy = bus_held;
		r.dropped  = drp;
		r.pending  = CNT_W'(mq_cnt);
		return r;
	endfunction

	function automatic void push_event(logic [1:0] kind, logic [ID_W-1:0] id);
		req_t ev;
		ev.req_type = kind;
		ev.mst_id   = id;
		event_q     = {event_q, ev};
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if (pol_rr && $urandom_range(3) != 0)
			return ID_W'($urandom_range(eff_masters() - 1));
		return ID_W'($urandom_range(7));
	endfunction

	task automatic report_mismatch(string msg);
		$display("word %0d: %s", word_num, msg);
		err_cnt++;
	endtask

	task automatic set_config(logic pol, logic [MC_W-1:0] mc);
		logic [CFG_DATA_W-1:0] pdata;
		pdata = CFG_DATA_W'($urandom_range(15));
		pdata[0] = pol;
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_POLICY;
		cfg_data <= pdata;
		@(posedge clk);
		cfg_idx  <= CFG_MASTER_COUNT;
		cfg_data <= mc;
		@(posedge clk);
		cfg_we   <= 1'b0;
		pol_rr = pol;
		mc_reg = mc;
	endtask

	task automatic drain();
		while (event_q.size() != 0 || req_ch.valid || grant_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic gen_traffic(int n);
		int made;
		int pick;
		int len;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				// burst of requests to fill the queue
				len = $urandom_range(10, 1);
				repeat (len) push_event(EV_REQ, pick_id());
				made += len;
			end else if (pick < 22) begin
				push_event(EV_REL, ID_W'($urandom_range(7)));
				push_event(EV_TICK, ID_W'($urandom_range(7)));
				made += 2;
			end else begin
				if (pick < 50)
					push_event(EV_REQ, pick_id());
				else if (pick < 75)
					push_event(EV_TICK, ID_W'($urandom_range(7)));
				else if (pick < 95)
					push_event(EV_REL, ID_W'($urandom_range(7)));
				else
					push_event(EV_NONE, ID_W'($urandom_range(7)));
				made++;
			end
		end
	endtask

	// event driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				grant_q = {grant_q, arb_predict(req_ch.data)};
			if (!req_ch.valid || req_ch.ready) begin
				if (event_q.size() != 0 && $urandom_range(99) >= src_idle) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= event_q[0];
					event_q.delete(0);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (grant_q.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = grant_q[0];
					grant_q.delete(0);
					if (rsp_ch.data.granted !== want.granted)
						report_mismatch($sformatf("granted got %0b expected %0b",
							rsp_ch.data.granted, want.granted));
					if (rsp_ch.data.owner !== want.owner)
						report_mismatch($sformatf("owner got %0d expected %0d",
							rsp_ch.data.owner, want.owner));
					if (rsp_ch.data.bus_busy !== want.bus_busy)
						report_mismatch($sformatf("bus_busy got %0b expected %0b",
							rsp_ch.data.bus_busy, want.bus_busy));
					if (rsp_ch.data.dropped !== want.dropped)
						report_mismatch($sformatf("dropped got %0b expected %0b",
							rsp_ch.data.dropped, want.dropped));
					if (rsp_ch.data.pending !== want.pending)
						report_mismatch($sformatf("pending got %0d expected %0d",
							rsp_ch.data.pending, want.pending));
				end
				word_num++;
			end
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_data     = '0;
		src_idle     = 17;
		snk_idle     = 69;
		mq_cnt       = 0;
		rr_ptr       = '0;
		bus_held     = 1'b0;
		cur_owner    = '0;
		pol_rr       = 1'b0;
		mc_reg       = MC_RESET;
		for (int i = 0; i < QDEPTH; i++)
			mq_ids[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// fifo order at reset settings
		push_event(EV_TICK, 3'd0);
		push_event(EV_REL, 3'd7);
		push_event(EV_NONE, 3'd5);
		push_event(EV_REQ, 3'd0);
		push_event(EV_REQ, 3'd7);
		push_event(EV_REQ, 3'd3);
		push_event(EV_REQ, 3'd5);
		push_event(EV_REQ, 3'd1);
		push_event(EV_REQ, 3'd2);
		push_event(EV_REQ, 3'd6);
		push_event(EV_REQ, 3'd4);
		push_event(EV_REQ, 3'd7);
		push_event(EV_TICK, 3'd0);
		push_event(EV_TICK, 3'd7);
		push_event(EV_REQ, 3'd2);
		push_event(EV_REL, 3'd0);
		push_event(EV_TICK, 3'd0);
		push_event(EV_REL, 3'd0);
		push_event(EV_REL, 3'd0);
		drain();

		// round robin over three masters, ids outside the rotation stay queued
		set_config(1'b1, 4'd3);
		push_event(EV_TICK, 3'd0);
		push_event(EV_REL, 3'd0);
		push_event(EV_TICK, 3'd0);
		push_event(EV_REL, 3'd0);
		push_event(EV_TICK, 3'd0);
		push_event(EV_TICK, 3'd0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				src_idle = 69;
				snk_idle = 17;
			end else if (ph == 8) begin
				src_idle = 0;
				snk_idle = 0;
			end
			set_config(ph_pol[ph][0], MC_W'(ph_mc[ph]));
			gen_traffic(ph == 11 ? 150 : 160);
			drain();
		end

		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("bus_arbiter_fifo_round_robin_core_tb: clean");
		else
			$display("bus_arbiter_fifo_round_robin_core_tb: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("bus_arbiter_fifo_round_robin_core_tb: errors");
		$finish;
	end

endmodule

FILE: bus_arbiter_fifo_round_robin_core.f
hdl/barb_pkg.sv
hdl/barb_if.sv
hdl/barb_ctrl.sv
hdl/barb_dp.sv
hdl/bus_arbiter_fifo_round_robin_core.sv
test/bus_arbiter_fifo_round_robin_core_tb.sv
